[rtl/pba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_pkg - path bandwidth admission shared definitions
// Sizes, codes, types and the link row layout used across the block.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int LINK_COUNT = 64;
    localparam int MAX_HOPS   = 8;

    localparam int LINK_ID_W = 6;
    localparam int BW_W      = 16;
    localparam int CAP_W     = 16;
    localparam int CHG_W     = 18;
    localparam int VERD_W    = 2;

    localparam int MEM_AW = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;
    localparam int HOP_W  = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
    localparam int CNT_W  = $clog2(MAX_HOPS + 1);

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_PATH = 1'b1;

    localparam logic MODE_OPTIMISTIC  = 1'b0;
    localparam logic MODE_PESSIMISTIC = 1'b1;

    localparam logic SEL_PRIMARY   = 1'b0;
    localparam logic SEL_ALTERNATE = 1'b1;

    localparam logic [VERD_W-1:0] VERDICT_REJECT    = 2'd0;
    localparam logic [VERD_W-1:0] VERDICT_PRIMARY   = 2'd1;
    localparam logic [VERD_W-1:0] VERDICT_ALTERNATE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PATH,
        S_CHK_RD,
        S_CHK_EV,
        S_CMT_RD,
        S_CMT_WR
    } t_state;

    typedef struct packed {
        logic [CAP_W-1:0] cap;
        logic [CHG_W-1:0] res;
    } t_link_row;

    typedef struct packed {
        logic [CNT_W-1:0] prim_cnt;
        logic [CNT_W-1:0] alt_cnt;
        logic [1:0]       ovf;
        logic [CHG_W-1:0] charge;
    } t_req_info;

    typedef struct packed {
        logic             fits;
        logic [CHG_W-1:0] sum_sat;
    } t_alu_out;

    function automatic logic link_in_range(input logic [LINK_ID_W-1:0] link);
        return 32'(link) < LINK_COUNT;
    endfunction

endpackage

[rtl/pba_link_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_link_mem - link capacity and reservation store
// One write and one registered read per cycle; per-row valid bits make
// unwritten rows read as zero straight after reset.
// ----------------------------------------------------------------------------
module pba_link_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [pba_pkg::MEM_AW-1:0]    i_waddr,
    input  pba_pkg::t_link_row            i_wdata,
    input  logic [pba_pkg::MEM_AW-1:0]    i_raddr,
    output pba_pkg::t_link_row            o_rdata
);

    pba_pkg::t_link_row r_mem [pba_pkg::LINK_COUNT];
    logic [pba_pkg::LINK_COUNT-1:0] r_valid;
    pba_pkg::t_link_row r_rdata;
    logic r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

[rtl/pba_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_alu - shared reservation adder and fit compare
// reserved + charge feeds both the fit test and the saturated commit value.
// ----------------------------------------------------------------------------
module pba_alu (
    input  pba_pkg::t_link_row               i_row,
    input  logic [pba_pkg::CHG_W-1:0]        i_charge,
    output pba_pkg::t_alu_out                o_res
);

    logic [pba_pkg::CHG_W:0] sum;
    logic [pba_pkg::CHG_W:0] cap_q;

    // 4*cap - reserved >= charge  <=>  reserved + charge <= 4*cap
    assign sum   = {1'b0, i_row.res} + {1'b0, i_charge};
    assign cap_q = (pba_pkg::CHG_W + 1)'({i_row.cap, 2'b00});

    assign o_res.fits    = (sum <= cap_q);
    assign o_res.sum_sat = sum[pba_pkg::CHG_W] ? '1 : sum[pba_pkg::CHG_W-1:0];

endmodule

[rtl/pba_path_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_path_buf - request collector
// Latches the request charge, gathers primary and alternate link lists and
// tracks counts and too-long flags.
// ----------------------------------------------------------------------------
module pba_path_buf (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic                             i_charge_mode,
    input  logic [pba_pkg::LINK_ID_W-1:0]    i_link_id,
    input  logic [pba_pkg::BW_W-1:0]         i_band_min,
    input  logic [pba_pkg::BW_W-1:0]         i_band_avg,
    input  logic [pba_pkg::BW_W-1:0]         i_band_max,
    input  logic                             i_alt_path,
    input  logic                             i_no_link,
    input  logic                             i_last_link,
    input  logic                             i_sel,
    input  logic [pba_pkg::HOP_W-1:0]        i_hop,
    output logic [pba_pkg::LINK_ID_W-1:0]    o_link,
    output pba_pkg::t_req_info               o_info
);

    logic [pba_pkg::LINK_ID_W-1:0] r_prim [pba_pkg::MAX_HOPS];
    logic [pba_pkg::LINK_ID_W-1:0] r_alt  [pba_pkg::MAX_HOPS];

    logic                      r_open, n_open;
    logic                      r_prim_done, n_prim_done;
    logic [pba_pkg::CNT_W-1:0] r_pc, n_pc;
    logic [pba_pkg::CNT_W-1:0] r_ac, n_ac;
    logic [1:0]                r_ovf, n_ovf;
    logic [pba_pkg::CHG_W-1:0] r_charge, n_charge;

    logic                      wr_p, wr_a;
    logic [pba_pkg::HOP_W-1:0] wr_idx;
    logic                      ends;

    logic [pba_pkg::CHG_W-1:0] peak;
    logic [pba_pkg::CHG_W+1:0] eq;
    logic [pba_pkg::CHG_W-1:0] charge_calc;

    // eq = 4*avg + max - min, two's complement, top bit is the sign
    assign peak = {i_band_max, 2'b00};
    assign eq   = (pba_pkg::CHG_W + 2)'({i_band_avg, 2'b00})
                + (pba_pkg::CHG_W + 2)'(i_band_max)
                - (pba_pkg::CHG_W + 2)'(i_band_min);

    always_comb begin
        if (i_charge_mode == pba_pkg::MODE_PESSIMISTIC) begin
            charge_calc = peak;
        end else if (eq[pba_pkg::CHG_W+1]) begin
            charge_calc = '0;
        end else if (eq[pba_pkg::CHG_W:0] > {1'b0, peak}) begin
            charge_calc = peak;
        end else begin
            charge_calc = eq[pba_pkg::CHG_W-1:0];
        end
    end

    assign ends = i_last_link | i_no_link;

    always_comb begin
        n_open      = r_open;
        n_prim_done = r_prim_done;
        n_pc        = r_pc;
        n_ac        = r_ac;
        n_ovf       = r_ovf;
        n_charge    = r_charge;
        wr_p        = 1'b0;
        wr_a        = 1'b0;
        wr_idx      = '0;
        if (i_accept) begin
            if (!r_open) begin
                n_open      = 1'b1;
                n_prim_done = 1'b0;
                n_pc        = '0;
                n_ac        = '0;
                n_ovf       = '0;
                n_charge    = charge_calc;
            end
            if (!i_alt_path) begin
                // primary words after the primary has ended are dropped
                if (!n_prim_done) begin
                    if (i_no_link) begin
                        n_pc     = '0;
                        n_ovf[0] = 1'b0;
                    end else if (n_pc < pba_pkg::CNT_W'(pba_pkg::MAX_HOPS)) begin
                        wr_p   = 1'b1;
                        wr_idx = n_pc[pba_pkg::HOP_W-1:0];
                        n_pc   = n_pc + 1'b1;
                    end else begin
                        n_ovf[0] = 1'b1;
                    end
                    if (ends) begin
                        n_prim_done = 1'b1;
                    end
                end
            end else begin
                n_prim_done = 1'b1;
                if (i_no_link) begin
                    n_ac     = '0;
                    n_ovf[1] = 1'b0;
                end else if (n_ac < pba_pkg::CNT_W'(pba_pkg::MAX_HOPS)) begin
                    wr_a   = 1'b1;
                    wr_idx = n_ac[pba_pkg::HOP_W-1:0];
                    n_ac   = n_ac + 1'b1;
                end else begin
                    n_ovf[1] = 1'b1;
                end
                if (ends) begin
                    n_open      = 1'b0;
                    n_prim_done = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_prim_done <= 1'b0;
            r_pc        <= '0;
            r_ac        <= '0;
            r_ovf       <= '0;
            r_charge    <= '0;
        end else begin
            r_open      <= n_open;
            r_prim_done <= n_prim_done;
            r_pc        <= n_pc;
            r_ac        <= n_ac;
            r_ovf       <= n_ovf;
            r_charge    <= n_charge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_p) begin
            r_prim[wr_idx] <= i_link_id;
        end
        if (wr_a) begin
            r_alt[wr_idx] <= i_link_id;
        end
    end

    assign o_link = (i_sel == pba_pkg::SEL_ALTERNATE) ? r_alt[i_hop] : r_prim[i_hop];

    assign o_info.prim_cnt = r_pc;
    assign o_info.alt_cnt  = r_ac;
    assign o_info.ovf      = r_ovf;
    assign o_info.charge   = r_charge;

endmodule

[rtl/path_bandwidth_admission_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_bandwidth_admission_unit - link bandwidth admission control
// Capacity loads and path link words in, one verdict per request out.
// ----------------------------------------------------------------------------
// Usage:
//   Input words are taken on start while busy is low. A capacity load or a
//   path link word that does not close the alternate path is taken without
//   leaving idle, so busy stays low. The word that closes the alternate path
//   starts the sequencer: each path first has its count and too-long flag
//   tested, then each hop is checked (link store read, then fit compare in
//   the shared adder) and, once a path fits, committed (read, then saturated
//   write back). A path fails at its first short link.
//   The verdict and charge show for one cycle on o_result_strobe, the same
//   cycle busy falls, so the next word may be taken alongside it.
//   The charge_mode register is written on i_cfg_valid; the port is always
//   ready. Reset empties every link store row, closes any open request and
//   sets optimistic mode. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module path_bandwidth_admission_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_req_type,
    input  logic [pba_pkg::LINK_ID_W-1:0]    i_link_id,
    input  logic [pba_pkg::CAP_W-1:0]        i_capacity,
    input  logic [pba_pkg::BW_W-1:0]         i_band_min,
    input  logic [pba_pkg::BW_W-1:0]         i_band_avg,
    input  logic [pba_pkg::BW_W-1:0]         i_band_max,
    input  logic                             i_alt_path,
    input  logic                             i_no_link,
    input  logic                             i_last_link,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_data,
    output logic                             o_result_strobe,
    output logic [pba_pkg::VERD_W-1:0]       o_verdict,
    output logic [pba_pkg::CHG_W-1:0]        o_charge_quarters
);

    pba_pkg::t_state r_state, n_state;
    logic                        r_sel, n_sel;
    logic [pba_pkg::HOP_W-1:0]   r_hop, n_hop;
    logic                        r_strobe, n_strobe;
    logic [pba_pkg::VERD_W-1:0]  r_verdict, n_verdict;
    logic [pba_pkg::CHG_W-1:0]   r_charge_q;
    logic                        r_charge_mode;

    logic accept, path_word, fire;
    logic [pba_pkg::LINK_ID_W-1:0] cur_link;
    pba_pkg::t_req_info info;
    logic [pba_pkg::CNT_W-1:0] cur_cnt;
    logic cur_ovf, last_hop;

    logic                        mem_we;
    logic [pba_pkg::MEM_AW-1:0]  mem_waddr;
    pba_pkg::t_link_row          mem_wdata;
    pba_pkg::t_link_row          mem_rdata;
    pba_pkg::t_alu_out           alu;

    assign accept    = start & ~busy;
    assign path_word = accept & (i_req_type == pba_pkg::REQ_PATH);
    assign fire      = path_word & i_alt_path & (i_last_link | i_no_link);

    pba_path_buf u_path_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (path_word),
        .i_charge_mode (r_charge_mode),
        .i_link_id     (i_link_id),
        .i_band_min    (i_band_min),
        .i_band_avg    (i_band_avg),
        .i_band_max    (i_band_max),
        .i_alt_path    (i_alt_path),
        .i_no_link     (i_no_link),
        .i_last_link   (i_last_link),
        .i_sel         (r_sel),
        .i_hop         (r_hop),
        .o_link        (cur_link),
        .o_info        (info)
    );

    // loads only come in while idle, commits only while busy
    always_comb begin
        if (r_state == pba_pkg::S_CMT_WR) begin
            mem_we        = 1'b1;
            mem_waddr     = pba_pkg::MEM_AW'(cur_link);
            mem_wdata.cap = mem_rdata.cap;
            mem_wdata.res = alu.sum_sat;
        end else begin
            mem_we        = accept & (i_req_type == pba_pkg::REQ_LOAD)
                          & pba_pkg::link_in_range(i_link_id);
            mem_waddr     = pba_pkg::MEM_AW'(i_link_id);
            mem_wdata.cap = i_capacity;
            mem_wdata.res = '0;
        end
    end

    pba_link_mem u_link_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (pba_pkg::MEM_AW'(cur_link)),
        .o_rdata (mem_rdata)
    );

    pba_alu u_alu (
        .i_row    (mem_rdata),
        .i_charge (info.charge),
        .o_res    (alu)
    );

    assign cur_cnt  = (r_sel == pba_pkg::SEL_ALTERNATE) ? info.alt_cnt : info.prim_cnt;
    assign cur_ovf  = info.ovf[r_sel];
    assign last_hop = (pba_pkg::CNT_W'(r_hop) == cur_cnt - 1'b1);

    always_comb begin
        n_state   = r_state;
        n_sel     = r_sel;
        n_hop     = r_hop;
        n_strobe  = 1'b0;
        n_verdict = r_verdict;
        unique case (r_state)
            pba_pkg::S_IDLE: begin
                if (fire) begin
                    n_sel   = pba_pkg::SEL_PRIMARY;
                    n_hop   = '0;
                    n_state = pba_pkg::S_PATH;
                end
            end
            pba_pkg::S_PATH: begin
                n_hop = '0;
                if (cur_cnt != '0 && !cur_ovf) begin
                    n_state = pba_pkg::S_CHK_RD;
                end else if (r_sel == pba_pkg::SEL_PRIMARY) begin
                    n_sel = pba_pkg::SEL_ALTERNATE;
                end else begin
                    n_strobe  = 1'b1;
                    n_verdict = pba_pkg::VERDICT_REJECT;
                    n_state   = pba_pkg::S_IDLE;
                end
            end
            pba_pkg::S_CHK_RD: begin
                if (pba_pkg::link_in_range(cur_link)) begin
                    n_state = pba_pkg::S_CHK_EV;
                end else if (r_sel == pba_pkg::SEL_PRIMARY) begin
                    n_sel   = pba_pkg::SEL_ALTERNATE;
                    n_state = pba_pkg::S_PATH;
                end else begin
                    n_strobe  = 1'b1;
                    n_verdict = pba_pkg::VERDICT_REJECT;
                    n_state   = pba_pkg::S_IDLE;
                end
            end
            pba_pkg::S_CHK_EV: begin
                if (!alu.fits) begin
                    if (r_sel == pba_pkg::SEL_PRIMARY) begin
                        n_sel   = pba_pkg::SEL_ALTERNATE;
                        n_state = pba_pkg::S_PATH;
                    end else begin
                        n_strobe  = 1'b1;
                        n_verdict = pba_pkg::VERDICT_REJECT;
                        n_state   = pba_pkg::S_IDLE;
                    end
                end else if (last_hop) begin
                    n_hop   = '0;
                    n_state = pba_pkg::S_CMT_RD;
                end else begin
                    n_hop   = r_hop + 1'b1;
                    n_state = pba_pkg::S_CHK_RD;
                end
            end
            pba_pkg::S_CMT_RD: begin
                n_state = pba_pkg::S_CMT_WR;
            end
            pba_pkg::S_CMT_WR: begin
                if (last_hop) begin
                    n_strobe  = 1'b1;
                    n_verdict = (r_sel == pba_pkg::SEL_ALTERNATE)
                              ? pba_pkg::VERDICT_ALTERNATE : pba_pkg::VERDICT_PRIMARY;
                    n_state   = pba_pkg::S_IDLE;
                end else begin
                    n_hop   = r_hop + 1'b1;
                    n_state = pba_pkg::S_CMT_RD;
                end
            end
            default: begin
                n_state = pba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= pba_pkg::S_IDLE;
            r_sel         <= pba_pkg::SEL_PRIMARY;
            r_hop         <= '0;
            r_strobe      <= 1'b0;
            r_charge_mode <= pba_pkg::MODE_OPTIMISTIC;
        end else begin
            r_state  <= n_state;
            r_sel    <= n_sel;
            r_hop    <= n_hop;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_charge_mode <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_strobe) begin
            r_verdict  <= n_verdict;
            r_charge_q <= (n_verdict == pba_pkg::VERDICT_REJECT) ? '0 : info.charge;
        end
    end

    assign busy              = (r_state != pba_pkg::S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_result_strobe   = r_strobe;
    assign o_verdict         = r_verdict;
    assign o_charge_quarters = r_charge_q;

endmodule

[rtl/pba_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_checker - port level checks for the admission unit
// Watches the top level ports only; bound to every instance of the unit.
// ----------------------------------------------------------------------------
module pba_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic                             i_req_type,
    input  logic                             i_alt_path,
    input  logic                             i_no_link,
    input  logic                             i_last_link,
    input  logic                             o_result_strobe,
    input  logic [pba_pkg::VERD_W-1:0]       o_verdict,
    input  logic [pba_pkg::CHG_W-1:0]        o_charge_quarters
);

    // a request only goes busy on the word that closes its alternate path
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start) && $past(i_req_type == pba_pkg::REQ_PATH)
                        && $past(i_alt_path) && $past(i_last_link || i_no_link))
        else $error("busy rose without a closing path word");

    // the verdict word ends a busy spell and busy is already down with it
    a_result_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy) && !busy)
        else $error("result word outside the end of a busy spell");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (o_verdict == pba_pkg::VERDICT_REJECT)
                         || (o_verdict == pba_pkg::VERDICT_PRIMARY)
                         || (o_verdict == pba_pkg::VERDICT_ALTERNATE))
        else $error("verdict code out of range");

    a_reject_no_charge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && (o_verdict == pba_pkg::VERDICT_REJECT)
        |-> (o_charge_quarters == '0))
        else $error("rejected request reports a charge");

endmodule

bind path_bandwidth_admission_unit pba_checker u_pba_checker (.*);
